@@ src/tmf_pkg.sv @@
// Shared constants and types for the trimmed mean window filter.
package tmf_pkg;

    // Window geometry and sample width.
    localparam int WINDOW_SIZE = 13;
    localparam int SAMPLE_BITS = 10;

    // Port field widths fixed by the interface.
    localparam int IN_BITS  = 10;
    localparam int OUT_BITS = 10;

    // Trim bounds on the sorted window: keep ranks TRIM_LOW .. TRIM_HIGH-1.
    localparam int TRIM_LOW_RAW  = (WINDOW_SIZE * 15) / 100;
    localparam int TRIM_LOW      = (TRIM_LOW_RAW > 1) ? TRIM_LOW_RAW : 1;
    localparam int TRIM_HIGH_RAW = ((WINDOW_SIZE * 85) / 100) + 1;
    localparam int TRIM_HIGH     = (TRIM_HIGH_RAW < (WINDOW_SIZE - 1)) ?
                                   TRIM_HIGH_RAW : (WINDOW_SIZE - 1);
    localparam int KEEP_COUNT    = TRIM_HIGH - TRIM_LOW;

    // Sum and reciprocal sizing for the divide by KEEP_COUNT.
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam int SUM_MAX    = KEEP_COUNT * SAMPLE_MAX;
    localparam int SUM_BITS   = $clog2(SUM_MAX + 1);
    localparam int DIV_SHIFT  = SUM_BITS + $clog2(KEEP_COUNT);
    localparam int RECIP_BITS = SUM_BITS + 2;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam longint RECIP_VAL =
        ((longint'(1) << DIV_SHIFT) + longint'(KEEP_COUNT) - 1) / longint'(KEEP_COUNT);

    // Index into the window.
    localparam int IDX_BITS = $clog2(WINDOW_SIZE);

    // Decoupling queue between front and back.
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [SUM_BITS-1:0]    t_sum;

    // One queued word: the slot to overwrite and the masked sample.
    typedef struct packed {
        t_idx    slot;
        t_sample sample;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

@@ src/tmf_if.sv @@
// Valid/ready channel interfaces for the filter's input and output words.
interface tmf_in_if
    import tmf_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [IN_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmf_out_if
    import tmf_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] smoothed;

    modport source (output valid, output smoothed, input ready);
    modport sink   (input valid, input smoothed, output ready);
endinterface

@@ src/trimmed_mean_window_filter_unit.sv @@
// From input accept to result valid a word passes the queue, 13 rank steps, the multiply and the load.
// The back end finishes one word before it takes the next, ranking one window entry per cycle.
// The input side keeps accepting into a two-word queue while the back end works.
// A finished result waits in the output register while the next word is processed.
// Reset (synchronous, active low) zeros the window, the slot pointer, queue and output valid.
module trimmed_mean_window_filter_unit
    import tmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmf_in_if.sink    i_in,
    tmf_out_if.source o_out
);

    // Front to queue: pushed word and queue status.
    logic      push;
    t_item     push_item;
    t_q_status q_status;

    // Queue to back: head word and pop strobe.
    t_item     head_item;
    logic      pop;

    // Accept words while the queue has room, tag each with its window slot.
    tmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    // Decouple the input handshake from the multi-cycle back end.
    tmf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    // Overwrite the oldest entry, rank every entry, sum the middle ranks,
    // then divide by the kept count through a reciprocal multiply.
    tmf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

@@ src/tmf_front.sv @@
// Front end: accept input words, mask samples and assign their window slot.
module tmf_front
    import tmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmf_in_if.sink    i_in,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_item     o_item
);

    t_idx r_slot;
    t_idx n_slot;

    assign i_in.ready    = !i_q_status.full;
    assign o_push        = i_in.valid && i_in.ready;
    assign o_item.slot   = r_slot;
    assign o_item.sample = t_sample'(i_in.sample);

    // Advance the oldest-entry pointer, wrap at the window end.
    always_comb begin
        if (r_slot == t_idx'(WINDOW_SIZE - 1)) begin
            n_slot = '0;
        end else begin
            n_slot = r_slot + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (o_push) begin
            r_slot <= n_slot;
        end
    end

endmodule

@@ src/tmf_fifo.sv @@
// Short queue of words between the front end and the back end.
module tmf_fifo
    import tmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;
    logic [Q_CNT_BITS-1:0] n_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_BITS'(Q_DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_BITS'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

@@ src/tmf_back.sv @@
// Back end: update the window, rank entries, sum the kept ones and divide.
module tmf_back
    import tmf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_item     i_item,
    output logic      o_pop,
    tmf_out_if.source o_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RANK = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [RECIP_BITS-1:0] RECIP_C = RECIP_BITS'(RECIP_VAL);

    t_sample                r_window [WINDOW_SIZE];
    logic [1:0]             r_state;
    t_idx                   r_idx;
    t_sum                   r_sum;
    logic [PROD_BITS-1:0]   r_prod;
    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_data;

    t_sample                key;
    logic [WINDOW_SIZE-1:0] less;
    t_idx                   rank;
    logic                   kept;
    t_sum                   n_sum;

    // Rank of the entry under the cursor: ties broken by position.
    always_comb begin
        key = r_window[r_idx];
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            less[j] = (r_window[j] < key) ||
                      ((r_window[j] == key) && (t_idx'(j) < r_idx));
        end
        rank  = t_idx'($countones(less));
        kept  = (rank >= t_idx'(TRIM_LOW)) && (rank < t_idx'(TRIM_HIGH));
        n_sum = r_sum + (kept ? t_sum'(key) : '0);
    end

    assign o_pop          = (r_state == ST_IDLE) && !i_q_status.empty;
    assign o_out.valid    = r_out_valid;
    assign o_out.smoothed = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW_SIZE; k++) begin
                r_window[k] <= '0;
            end
        end else begin
            // Drop the word once taken; a load in ST_DONE replaces it instead.
            if (r_out_valid && o_out.ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_window[i_item.slot] <= i_item.sample;
                        r_idx                 <= '0;
                        r_sum                 <= '0;
                        r_state               <= ST_RANK;
                    end
                end
                ST_RANK: begin
                    r_sum <= n_sum;
                    if (r_idx == t_idx'(WINDOW_SIZE - 1)) begin
                        r_state <= ST_MUL;
                    end else begin
                        r_idx <= r_idx + t_idx'(1);
                    end
                end
                ST_MUL: begin
                    r_prod  <= {{RECIP_BITS{1'b0}}, r_sum} * {{SUM_BITS{1'b0}}, RECIP_C};
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free.
                    if (!r_out_valid || o_out.ready) begin
                        r_out_data  <= OUT_BITS'(r_prod >> DIV_SHIFT);
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RANK) |-> (r_idx <= t_idx'(WINDOW_SIZE - 1)))
        else $error("rank cursor past window end");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> ((r_state == ST_RANK) && (r_idx == '0)))
        else $error("pop did not start a ranking pass");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_sum <= t_sum'(SUM_MAX)))
        else $error("trimmed sum exceeds kept-entry bound");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ((r_prod >> DIV_SHIFT) <= PROD_BITS'(SAMPLE_MAX)))
        else $error("quotient out of sample range");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking bench for the trimmed mean window filter with random flow control on both channels.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmf_pkg::*;

    // Abort if neither channel moves a word for this many cycles.
    localparam int STALL_LIMIT  = 1000;
    // Settle time after the last result: longer than the block's latency.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 700;

    // Shapes of the random sample runs.
    typedef enum int {
        RUN_UNIFORM,
        RUN_STEADY,
        RUN_SPIKY,
        RUN_RAMP,
        RUN_RAILS
    } t_run_kind;

    logic i_clk;
    logic i_rst_n;

    tmf_in_if  in_ch();
    tmf_out_if out_ch();

    trimmed_mean_window_filter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Samples still to be offered, and the means the block owes us.
    t_sample pending_samples[$];
    t_sample expected_means[$];

    // Shadow of the block's window and its overwrite pointer.
    t_sample window_copy[WINDOW_SIZE];
    int      next_slot;

    int samples_taken;
    int total_samples;
    int fail_count;
    int idle_cycles;

    // Run the three flow-control phases by progress through the stimulus:
    // receiver sparse first, then sender sparse, then full speed.
    function automatic int sender_idle_pct();
        if (samples_taken < total_samples / 3)
            return 28;
        else if (samples_taken < (2 * total_samples) / 3)
            return 72;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (samples_taken < total_samples / 3)
            return 72;
        else if (samples_taken < (2 * total_samples) / 3)
            return 28;
        return 0;
    endfunction

    // Overwrite the oldest entry, order a copy of the window, drop the
    // lowest and highest ranks and return the truncated mean of the rest.
    function automatic t_sample window_trimmed_mean(t_sample sample);
        t_sample     ranked[WINDOW_SIZE];
        t_sample     key;
        int          j;
        int unsigned total;
        int unsigned kept;
        window_copy[next_slot] = sample;
        next_slot = (next_slot == WINDOW_SIZE - 1) ? 0 : next_slot + 1;
        ranked = window_copy;
        for (int i = 1; i < WINDOW_SIZE; i++) begin
            key = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > key) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        total = 0;
        kept  = 0;
        for (int i = TRIM_LOW; i < TRIM_HIGH; i++) begin
            total += ranked[i];
            kept++;
        end
        if (kept == 0)
            return '0;
        return t_sample'(total / kept);
    endfunction

    // Clamp a level plus noise into the converter range.
    function automatic t_sample clamp_sample(int value);
        if (value < 0)
            return '0;
        if (value > SAMPLE_MAX)
            return t_sample'(SAMPLE_MAX);
        return t_sample'(value);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hold reset once, at the start.
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Build the stimulus, then wait for every mean to come back.
    initial begin
        t_run_kind kind;
        int        run_len;
        int        level;
        int        step;
        int        produced;
        samples_taken = 0;
        fail_count    = 0;
        next_slot     = 0;
        foreach (window_copy[i])
            window_copy[i] = '0;

        // Start-up: full-scale words land on a window of reset zeros.
        pending_samples.push_back(10'h3FF);
        pending_samples.push_back(10'h3FF);
        pending_samples.push_back(10'h3FF);
        pending_samples.push_back(10'h000);
        // Toggle every bit through both values.
        pending_samples.push_back(10'h155);
        pending_samples.push_back(10'h2AA);
        pending_samples.push_back(10'h001);
        pending_samples.push_back(10'h200);
        pending_samples.push_back(10'h1FF);
        // Fill the whole window with full scale to reach the top result.
        repeat (WINDOW_SIZE)
            pending_samples.push_back(10'h3FF);

        // Random runs of assorted shapes: noise, steady levels with jitter,
        // outliers that the trim must reject, ramps, and rail-to-rail words.
        produced = 0;
        while (produced < RANDOM_WORDS) begin
            kind    = t_run_kind'($urandom_range(RUN_RAILS, RUN_UNIFORM));
            run_len = $urandom_range(30, 5);
            level   = $urandom_range(SAMPLE_MAX);
            step    = $urandom_range(40) - 20;
            for (int k = 0; k < run_len; k++) begin
                case (kind)
                    RUN_UNIFORM: begin
                        pending_samples.push_back(t_sample'($urandom));
                    end
                    RUN_STEADY: begin
                        pending_samples.push_back(
                            clamp_sample(level + int'($urandom_range(16)) - 8));
                    end
                    RUN_SPIKY: begin
                        if ($urandom_range(4) == 0)
                            pending_samples.push_back(
                                $urandom_range(1) ? t_sample'(SAMPLE_MAX) : '0);
                        else
                            pending_samples.push_back(
                                clamp_sample(level + int'($urandom_range(6)) - 3));
                    end
                    RUN_RAMP: begin
                        pending_samples.push_back(t_sample'(level + k * step));
                    end
                    default: begin
                        pending_samples.push_back(
                            $urandom_range(1) ? t_sample'(SAMPLE_MAX) : '0);
                    end
                endcase
            end
            produced += run_len;
        end
        total_samples = pending_samples.size();

        while (samples_taken != total_samples || expected_means.size() != 0)
            @(posedge i_clk);
        // Let any stray extra word surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Sender: log each accepted word with its predicted mean, then offer the
    // next one unless this cycle idles. Hold the word while ready is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.sample <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_means.push_back(window_trimmed_mean(in_ch.sample));
                samples_taken <= samples_taken + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    in_ch.valid  <= 1'b1;
                    in_ch.sample <= pending_samples.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each accepted mean with the oldest prediction and
    // stall ready at random for the next cycle.
    always @(posedge i_clk) begin : result_check
        t_sample want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_means.size() == 0) begin
                    $display("%t unexpected smoothed word: expected none, actual %0d",
                             $time, out_ch.smoothed);
                    fail_count++;
                end else begin
                    want = expected_means.pop_front();
                    if (out_ch.smoothed !== want) begin
                        $display("%t smoothed mismatch: expected %0d, actual %0d",
                                 $time, want, out_ch.smoothed);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog: drop the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
src/tmf_pkg.sv
src/tmf_if.sv
src/tmf_front.sv
src/tmf_fifo.sv
src/tmf_back.sv
src/trimmed_mean_window_filter_unit.sv
tb/tb.sv
